/* src/nsf_pkg.sv */
// Shared constants, types and codes of the NMEA sentence framer.
package nsf_pkg;

  localparam int LINE_MAX = 128;
  localparam int SLOTS    = 8;
  localparam int POS_W    = $clog2(LINE_MAX);
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int TYPE_W   = 24;
  localparam int CFG_IDX_W = 1;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [POS_W-1:0] TYPE_CHAR1_POS = POS_W'(3);
  localparam logic [POS_W-1:0] TYPE_CHAR2_POS = POS_W'(4);
  localparam logic [POS_W-1:0] TYPE_END_POS   = POS_W'(5);
  localparam logic [POS_W-1:0] TAIL_MIN_POS   = POS_W'(7);
  localparam logic [POS_W-1:0] LAST_POS       = POS_W'(LINE_MAX - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT     = SLOT_W'(SLOTS - 1);

  localparam logic [TYPE_W-1:0] TYPE_A_RESET = 24'h474741;
  localparam logic [TYPE_W-1:0] TYPE_B_RESET = 24'h475356;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TYPE_A = 1'b0,
    CFG_TYPE_B = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IGNORED  = 3'd0,
    ST_STORED   = 3'd1,
    ST_REJECTED = 3'd2,
    ST_COMPLETE = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  // Framing state that the classifier reads.
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [7:0]        type_char_one;
    logic [7:0]        type_char_two;
    logic [7:0]        prev_byte;
    logic [SLOT_W-1:0] slot;
  } frame_state_t;

  // Decision for one byte: result fields plus state update controls.
  typedef struct packed {
    status_t           status;
    logic [POS_W-1:0]  byte_position;
    logic [POS_W-1:0]  sentence_length;
    logic [SLOT_W-1:0] slot_index;
    logic              pos_advance;
    logic              pos_clear;
    logic              slot_advance;
    logic              keep_char_one;
    logic              keep_char_two;
  } frame_decision_t;

endpackage

/* src/nsf_channels.sv */
// Valid/ready channel interfaces for received bytes and framing results.
interface nsf_in_if;
  import nsf_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsf_out_if;
  import nsf_pkg::*;
  logic              valid;
  logic              ready;
  status_t           status;
  logic [POS_W-1:0]  byte_position;
  logic [POS_W-1:0]  sentence_length;
  logic [SLOT_W-1:0] slot_index;

  modport source (output valid, output status, output byte_position,
                  output sentence_length, output slot_index, input ready);
  modport sink   (input valid, input status, input byte_position,
                  input sentence_length, input slot_index, output ready);
endinterface

/* src/nsf_classify.sv */
// Per-byte sentence classifier: start, type match, CR/LF end and line limit.
module nsf_classify
  import nsf_pkg::*;
(
  input  logic [7:0]        rx_byte,
  input  frame_state_t      st,
  input  logic [TYPE_W-1:0] type_a,
  input  logic [TYPE_W-1:0] type_b,
  output frame_decision_t   dec
);

  logic [TYPE_W-1:0] packed_type;
  logic              type_ok;
  logic              line_end;

  assign packed_type = {st.type_char_one, st.type_char_two, rx_byte};
  assign type_ok     = (packed_type == type_a) || (packed_type == type_b);
  assign line_end    = (st.pos > TAIL_MIN_POS) && (rx_byte == CH_LF)
                       && (st.prev_byte == CH_CR);

  always_comb begin
    dec                 = '0;
    dec.status          = ST_STORED;
    dec.byte_position   = st.pos;
    dec.keep_char_one   = (st.pos == TYPE_CHAR1_POS);
    dec.keep_char_two   = (st.pos == TYPE_CHAR2_POS);
    if (st.pos == '0 && rx_byte != CH_START) begin
      dec.status        = ST_IGNORED;
      dec.byte_position = '0;
      dec.keep_char_one = 1'b0;
      dec.keep_char_two = 1'b0;
    end else if (st.pos == TYPE_END_POS && !type_ok) begin
      dec.status    = ST_REJECTED;
      dec.pos_clear = 1'b1;
    end else if (line_end) begin
      dec.status          = ST_COMPLETE;
      dec.sentence_length = st.pos;
      dec.slot_index      = st.slot;
      dec.slot_advance    = 1'b1;
      dec.pos_clear       = 1'b1;
    end else if (st.pos == LAST_POS) begin
      dec.status    = ST_OVERFLOW;
      dec.pos_clear = 1'b1;
    end else begin
      dec.pos_advance = 1'b1;
    end
  end

endmodule

/* src/nmea_sentence_framer_unit.sv */
// Top level of the NMEA sentence framer: state, config and result register.
//
//   channel  direction  transaction payload
//   in_ch    sink       rx_byte (8)
//   out_ch   source     status (3), byte_position (7), sentence_length (7),
//                       slot_index (3)
//   cfg_*    write      cfg_index selects type_a/type_b, cfg_wdata (24)
//
// One byte per cycle unless out_ch stalls; each result appears in the cycle
// after acceptance, from a single result register loaded by the classifier.
// in_ch.ready is high while the result register is empty or being taken, so
// a new byte enters in the same cycle that the previous result leaves.
// A stall on out_ch holds the result and blocks in_ch; no state moves.
// Synchronous active-low reset clears framing state and loads GGA and GSV.
module nmea_sentence_framer_unit
  import nsf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  nsf_in_if.sink               in_ch,
  nsf_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TYPE_W-1:0]    cfg_wdata
);

  logic [TYPE_W-1:0] type_a_r;
  logic [TYPE_W-1:0] type_b_r;
  frame_state_t      state_r;
  frame_state_t      state_nxt;
  frame_decision_t   dec;
  logic              in_fire;

  logic              out_valid_r;
  logic              out_valid_nxt;
  status_t           status_r;
  logic [POS_W-1:0]  byte_position_r;
  logic [POS_W-1:0]  sentence_length_r;
  logic [SLOT_W-1:0] slot_index_r;

  // Accept whenever the result register is free or draining this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  nsf_classify u_classify (
    .rx_byte (in_ch.rx_byte),
    .st      (state_r),
    .type_a  (type_a_r),
    .type_b  (type_b_r),
    .dec     (dec)
  );

  // Next framing state for an accepted byte.
  always_comb begin
    state_nxt           = state_r;
    state_nxt.prev_byte = in_ch.rx_byte;
    if (dec.keep_char_one) begin
      state_nxt.type_char_one = in_ch.rx_byte;
    end
    if (dec.keep_char_two) begin
      state_nxt.type_char_two = in_ch.rx_byte;
    end
    if (dec.pos_clear) begin
      state_nxt.pos = '0;
    end else if (dec.pos_advance) begin
      state_nxt.pos = state_r.pos + POS_W'(1);
    end
    // Ring wraps and overwrites; no full check.
    if (dec.slot_advance) begin
      state_nxt.slot = (state_r.slot == LAST_SLOT) ? '0 : state_r.slot + SLOT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
      type_a_r    <= TYPE_A_RESET;
      type_b_r    <= TYPE_B_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        state_r <= state_nxt;
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TYPE_A: type_a_r <= cfg_wdata;
          CFG_TYPE_B: type_b_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Result payload: load on accept, hold while stalled.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r          <= dec.status;
      byte_position_r   <= dec.byte_position;
      sentence_length_r <= dec.sentence_length;
      slot_index_r      <= dec.slot_index;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = status_r;
  assign out_ch.byte_position   = byte_position_r;
  assign out_ch.sentence_length = sentence_length_r;
  assign out_ch.slot_index      = slot_index_r;

`ifndef SYNTHESIS
  // Completion, rejection and overflow restart the sentence.
  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (dec.status == ST_COMPLETE || dec.status == ST_REJECTED ||
                 dec.status == ST_OVERFLOW)) |=> (state_r.pos == '0))
    else $error("position not cleared after sentence end");

  // Ring slot moves only on a completed sentence.
  a_slot_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && dec.status == ST_COMPLETE) |=> $stable(state_r.slot))
    else $error("ring slot moved without a completed sentence");

  // A completed sentence reports its length at the line feed position.
  a_len_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_COMPLETE) |->
      (sentence_length_r == byte_position_r && byte_position_r > TAIL_MIN_POS))
    else $error("completed sentence length mismatch");

  // Bytes ignored while waiting for start carry position zero.
  a_ignored_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_IGNORED) |-> (byte_position_r == '0))
    else $error("ignored byte with nonzero position");
`endif

endmodule
